@@ rtl/max_flow_edmonds_karp_defines.svh @@
// Assertion macros for the max-flow block.
// Included by the top level; define NO_ASSERTIONS to compile them out.
`ifndef MAX_FLOW_EDMONDS_KARP_DEFINES_SVH
`define MAX_FLOW_EDMONDS_KARP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MFEK_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("max flow: same-cycle check failed");
`define MFEK_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("max flow: next-cycle check failed");
`else
`define MFEK_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define MFEK_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

@@ rtl/mfek_pkg.sv @@
// Shared types and constants for the max-flow block.
// No dependencies.
package mfek_pkg;
    localparam int NODES_DEF = 1024;
    localparam int ARCS_DEF  = 4096;
    localparam int NODE_FW   = 10;
    localparam int CAP_W     = 30;
    localparam int FLOW_W    = 40;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SINK   = 2'd1;

    localparam logic [CAP_W:0] BOTTLENECK_INIT = 31'h4000_0000;

    typedef struct packed {
        logic [NODE_FW-1:0] from_node;
        logic [NODE_FW-1:0] to_node;
        logic [CAP_W-1:0]   capacity;
        logic               last_edge;
    } edge_t;

    typedef struct packed {
        logic [FLOW_W-1:0] max_flow;
        logic              overflow;
    } result_t;
endpackage

@@ rtl/mfek_arc_table.sv @@
// Arc table: one word per forward/reverse arc pair, read by arc index.
// Depends on mfek_pkg.
module mfek_arc_table
    import mfek_pkg::*;
#(
    parameter int NW  = 10,
    parameter int PAW = 11,
    parameter int PAIRS = 2048
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [PAW-1:0]   wr_pair,
    input  logic [NW-1:0]    wr_from,
    input  logic [NW-1:0]    wr_to,
    input  logic [CAP_W-1:0] wr_res_even,
    input  logic [CAP_W-1:0] wr_res_odd,
    input  logic             rd_en,
    input  logic [PAW:0]     rd_arc,
    output logic [NW-1:0]    arc_tail,
    output logic [NW-1:0]    arc_head,
    output logic [CAP_W-1:0] arc_res,
    output logic             arc_odd,
    output logic [CAP_W-1:0] res_even,
    output logic [CAP_W-1:0] res_odd
);
    localparam int WW = 2*NW + 2*CAP_W;

    logic [WW-1:0]    pair_mem [PAIRS];
    logic [WW-1:0]    rd_word_reg;
    logic             odd_reg;
    logic [NW-1:0]    from_q;
    logic [NW-1:0]    to_q;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pair_mem[wr_pair] <= {wr_from, wr_to, wr_res_even, wr_res_odd};
        end
        if (rd_en)
        begin
            rd_word_reg <= pair_mem[rd_arc[PAW:1]];
            odd_reg     <= rd_arc[0];
        end
    end

    assign {from_q, to_q, res_even, res_odd} = rd_word_reg;
    // odd arc is the reverse direction of the stored edge
    assign arc_tail = odd_reg ? to_q : from_q;
    assign arc_head = odd_reg ? from_q : to_q;
    assign arc_res  = odd_reg ? res_odd : res_even;
    assign arc_odd  = odd_reg;
endmodule

@@ rtl/max_flow_edmonds_karp.sv @@
// Max flow (Edmonds-Karp). Edges load at one item per cycle; the last edge starts the search.
// Each search clears the reached marks of all NODES nodes, then scans every stored arc for
// every dequeued node, then walks the found path twice: for the bottleneck, then to augment.
// Result appears after the last augmenting search fails; the arc table port is the bottleneck.
// rst_n async active low clears control state; arc table and scratch memories are not cleared.
`include "max_flow_edmonds_karp_defines.svh"
module max_flow_edmonds_karp
    import mfek_pkg::*;
#(
    parameter int NODES = NODES_DEF,
    parameter int ARCS  = ARCS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 edge_valid,
    output logic                 edge_ready,
    input  edge_t                edge_item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [NODE_FW-1:0]   cfg_data
);
    localparam int NW    = $clog2(NODES);
    localparam int PAIRS = ARCS / 2;
    localparam int PAW   = (PAIRS > 1) ? $clog2(PAIRS) : 1;
    localparam int AIW   = PAW + 1;
    localparam int PCW   = $clog2(PAIRS + 1);

    typedef enum logic [15:0] {
        S_LOAD    = 16'h0001,
        S_CHECK   = 16'h0002,
        S_CLR     = 16'h0004,
        S_SEED    = 16'h0008,
        S_POP     = 16'h0010,
        S_POP_W   = 16'h0020,
        S_ARC_RD  = 16'h0040,
        S_ARC_CHK = 16'h0080,
        S_VIS_CHK = 16'h0100,
        S_W_RD    = 16'h0200,
        S_W_PB    = 16'h0400,
        S_W_PR    = 16'h0800,
        S_U_RD    = 16'h1000,
        S_U_PB    = 16'h2000,
        S_U_PR    = 16'h4000,
        S_DONE    = 16'h8000
    } state_t;

    state_t               state_reg, state_next;
    logic [NODE_FW-1:0]   src_reg, snk_reg;
    logic [PCW-1:0]       pair_count_reg, pair_count_next;
    logic                 dropped_reg, dropped_next;
    logic [FLOW_W:0]      flow_reg, flow_next;
    logic [NW-1:0]        clr_idx_reg, clr_idx_next;
    logic [NW:0]          qhead_reg, qhead_next;
    logic [NW:0]          qtail_reg, qtail_next;
    logic                 found_reg, found_next;
    logic [NW-1:0]        u_reg, u_next;
    logic [AIW:0]         arc_idx_reg, arc_idx_next;
    logic [NW-1:0]        node_reg, node_next;
    logic [CAP_W:0]       amt_reg, amt_next;
    logic [PAW-1:0]       pa_reg, pa_next;
    logic                 result_valid_reg, result_valid_next;
    result_t              result_reg, result_next;

    logic [NW-1:0]        s_node, t_node;
    logic                 st_ok;
    logic                 ep_ok;
    logic [NW-1:0]        e_from, e_to;
    logic [AIW:0]         arc_count;
    logic [FLOW_W+1:0]    flow_sum;

    // arc table
    logic                 at_we, at_re;
    logic [PAW-1:0]       at_wpair;
    logic [NW-1:0]        at_wfrom, at_wto;
    logic [CAP_W-1:0]     at_wres_e, at_wres_o;
    logic [AIW-1:0]       at_rarc;
    logic [NW-1:0]        arc_tail, arc_head;
    logic [CAP_W-1:0]     arc_res, res_even, res_odd;
    logic                 arc_odd;

    // scratch memories
    logic                 reached_mem [NODES];
    logic [NW-1:0]        queue_mem [NODES];
    logic [AIW-1:0]       back_mem [NODES];
    logic                 r_we, r_re, r_wdata, r_rd_reg;
    logic [NW-1:0]        r_addr;
    logic                 q_we, q_re;
    logic [NW-1:0]        q_waddr, q_wdata, q_rd_reg;
    logic                 pb_we, pb_re;
    logic [NW-1:0]        pb_addr;
    logic [AIW-1:0]       pb_rd_reg;

    mfek_arc_table #(.NW(NW), .PAW(PAW), .PAIRS(PAIRS)) u_arcs (
        .clk         (clk),
        .wr_en       (at_we),
        .wr_pair     (at_wpair),
        .wr_from     (at_wfrom),
        .wr_to       (at_wto),
        .wr_res_even (at_wres_e),
        .wr_res_odd  (at_wres_o),
        .rd_en       (at_re),
        .rd_arc      (at_rarc),
        .arc_tail    (arc_tail),
        .arc_head    (arc_head),
        .arc_res     (arc_res),
        .arc_odd     (arc_odd),
        .res_even    (res_even),
        .res_odd     (res_odd)
    );

    assign s_node     = NW'(src_reg);
    assign t_node     = NW'(snk_reg);
    assign st_ok      = (32'(src_reg) < NODES) && (32'(snk_reg) < NODES) && (src_reg != snk_reg);
    assign ep_ok      = (32'(edge_item.from_node) < NODES) && (32'(edge_item.to_node) < NODES);
    assign e_from     = NW'(edge_item.from_node);
    assign e_to       = NW'(edge_item.to_node);
    assign arc_count  = (AIW+1)'({pair_count_reg, 1'b0});
    assign flow_sum   = {1'b0, flow_reg} + (FLOW_W+2)'(amt_reg);
    assign edge_ready = (state_reg == S_LOAD);
    assign cfg_ready  = 1'b1;
    assign result_valid = result_valid_reg;
    assign result_item  = result_reg;

    always_comb
    begin
        state_next        = state_reg;
        pair_count_next   = pair_count_reg;
        dropped_next      = dropped_reg;
        flow_next         = flow_reg;
        clr_idx_next      = clr_idx_reg;
        qhead_next        = qhead_reg;
        qtail_next        = qtail_reg;
        found_next        = found_reg;
        u_next            = u_reg;
        arc_idx_next      = arc_idx_reg;
        node_next         = node_reg;
        amt_next          = amt_reg;
        pa_next           = pa_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;

        at_we     = 1'b0;
        at_re     = 1'b0;
        at_wpair  = pa_reg;
        at_wfrom  = arc_odd ? arc_head : arc_tail;
        at_wto    = arc_odd ? arc_tail : arc_head;
        at_wres_e = res_even;
        at_wres_o = res_odd;
        at_rarc   = arc_idx_reg[AIW-1:0];
        r_we      = 1'b0;
        r_re      = 1'b0;
        r_wdata   = 1'b0;
        r_addr    = clr_idx_reg;
        q_we      = 1'b0;
        q_re      = 1'b0;
        q_waddr   = qtail_reg[NW-1:0];
        q_wdata   = arc_head;
        pb_we     = 1'b0;
        pb_re     = 1'b0;
        pb_addr   = node_reg;

        unique case (state_reg)
            S_LOAD:
            begin
                if (edge_valid)
                begin
                    if (ep_ok)
                    begin
                        if (32'(pair_count_reg) < PAIRS)
                        begin
                            at_we           = 1'b1;
                            at_wpair        = pair_count_reg[PAW-1:0];
                            at_wfrom        = e_from;
                            at_wto          = e_to;
                            at_wres_e       = edge_item.capacity;
                            at_wres_o       = '0;
                            pair_count_next = pair_count_reg + PCW'(1);
                        end
                        else
                        begin
                            dropped_next = 1'b1;
                        end
                    end
                    if (edge_item.last_edge)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                flow_next    = '0;
                clr_idx_next = '0;
                state_next   = st_ok ? S_CLR : S_DONE;
            end
            S_CLR:
            begin
                r_we = 1'b1;
                if (clr_idx_reg == NW'(NODES - 1))
                begin
                    state_next = S_SEED;
                end
                clr_idx_next = clr_idx_reg + NW'(1);
            end
            S_SEED:
            begin
                r_we       = 1'b1;
                r_wdata    = 1'b1;
                r_addr     = s_node;
                q_we       = 1'b1;
                q_waddr    = '0;
                q_wdata    = s_node;
                qhead_next = '0;
                qtail_next = (NW+1)'(1);
                found_next = 1'b0;
                state_next = S_POP;
            end
            S_POP:
            begin
                if (found_reg)
                begin
                    node_next  = t_node;
                    amt_next   = BOTTLENECK_INIT;
                    state_next = S_W_RD;
                end
                else if (qhead_reg < qtail_reg)
                begin
                    q_re       = 1'b1;
                    state_next = S_POP_W;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_POP_W:
            begin
                u_next       = q_rd_reg;
                qhead_next   = qhead_reg + (NW+1)'(1);
                arc_idx_next = '0;
                state_next   = S_ARC_RD;
            end
            S_ARC_RD:
            begin
                if (arc_idx_reg == arc_count)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    at_re      = 1'b1;
                    state_next = S_ARC_CHK;
                end
            end
            S_ARC_CHK:
            begin
                if ((arc_tail == u_reg) && (arc_res != '0))
                begin
                    r_re       = 1'b1;
                    r_addr     = arc_head;
                    state_next = S_VIS_CHK;
                end
                else
                begin
                    arc_idx_next = arc_idx_reg + (AIW+1)'(1);
                    state_next   = S_ARC_RD;
                end
            end
            S_VIS_CHK:
            begin
                r_addr = arc_head;
                if (!r_rd_reg)
                begin
                    r_we    = 1'b1;
                    r_wdata = 1'b1;
                    pb_we   = 1'b1;
                    pb_addr = arc_head;
                    if (32'(qtail_reg) < NODES)
                    begin
                        q_we       = 1'b1;
                        qtail_next = qtail_reg + (NW+1)'(1);
                    end
                    if (arc_head == t_node)
                    begin
                        found_next = 1'b1;
                    end
                end
                arc_idx_next = arc_idx_reg + (AIW+1)'(1);
                state_next   = S_ARC_RD;
            end
            S_W_RD:
            begin
                if (node_reg == s_node)
                begin
                    node_next  = t_node;
                    state_next = S_U_RD;
                end
                else
                begin
                    pb_re      = 1'b1;
                    state_next = S_W_PB;
                end
            end
            S_W_PB:
            begin
                at_re      = 1'b1;
                at_rarc    = pb_rd_reg;
                state_next = S_W_PR;
            end
            S_W_PR:
            begin
                if ({1'b0, arc_res} < amt_reg)
                begin
                    amt_next = {1'b0, arc_res};
                end
                node_next  = arc_tail;
                state_next = S_W_RD;
            end
            S_U_RD:
            begin
                if (node_reg == s_node)
                begin
                    flow_next    = flow_sum[FLOW_W+1] ? '1 : flow_sum[FLOW_W:0];
                    clr_idx_next = '0;
                    state_next   = S_CLR;
                end
                else
                begin
                    pb_re      = 1'b1;
                    state_next = S_U_PB;
                end
            end
            S_U_PB:
            begin
                at_re      = 1'b1;
                at_rarc    = pb_rd_reg;
                pa_next    = pb_rd_reg[AIW-1:1];
                state_next = S_U_PR;
            end
            S_U_PR:
            begin
                // push along the path arc, give back on its partner
                at_we     = 1'b1;
                at_wres_e = arc_odd ? res_even + amt_reg[CAP_W-1:0]
                                    : res_even - amt_reg[CAP_W-1:0];
                at_wres_o = arc_odd ? res_odd - amt_reg[CAP_W-1:0]
                                    : res_odd + amt_reg[CAP_W-1:0];
                node_next  = arc_tail;
                state_next = S_U_RD;
            end
            S_DONE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next    = 1'b1;
                    result_next.max_flow = flow_reg[FLOW_W] ? '1 : flow_reg[FLOW_W-1:0];
                    result_next.overflow = dropped_reg;
                    pair_count_next      = '0;
                    dropped_next         = 1'b0;
                    flow_next            = '0;
                    state_next           = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_LOAD;
            src_reg          <= '0;
            snk_reg          <= NODE_FW'(1);
            pair_count_reg   <= '0;
            dropped_reg      <= 1'b0;
            flow_reg         <= '0;
            clr_idx_reg      <= '0;
            qhead_reg        <= '0;
            qtail_reg        <= '0;
            found_reg        <= 1'b0;
            arc_idx_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            pair_count_reg   <= pair_count_next;
            dropped_reg      <= dropped_next;
            flow_reg         <= flow_next;
            clr_idx_reg      <= clr_idx_next;
            qhead_reg        <= qhead_next;
            qtail_reg        <= qtail_next;
            found_reg        <= found_next;
            arc_idx_reg      <= arc_idx_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && (cfg_index == REG_SOURCE))
            begin
                src_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_index == REG_SINK))
            begin
                snk_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg      <= u_next;
        node_reg   <= node_next;
        amt_reg    <= amt_next;
        pa_reg     <= pa_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (r_we)
        begin
            reached_mem[r_addr] <= r_wdata;
        end
        if (r_re)
        begin
            r_rd_reg <= reached_mem[r_addr];
        end
        if (q_we)
        begin
            queue_mem[q_waddr] <= q_wdata;
        end
        if (q_re)
        begin
            q_rd_reg <= queue_mem[qhead_reg[NW-1:0]];
        end
        if (pb_we)
        begin
            back_mem[pb_addr] <= arc_idx_reg[AIW-1:0];
        end
        if (pb_re)
        begin
            pb_rd_reg <= back_mem[pb_addr];
        end
    end

    `MFEK_ASSERT_IMP(a_queue_order, clk, rst_n, state_reg == S_POP, qhead_reg <= qtail_reg)
    `MFEK_ASSERT_IMP(a_scan_bound, clk, rst_n, state_reg == S_ARC_RD, arc_idx_reg <= arc_count)
    `MFEK_ASSERT_NXT(a_result_src, clk, rst_n, !result_valid_reg && state_reg != S_DONE, !result_valid_reg)
endmodule
